@@ hw/rtl/masked_byte_pattern_search_core_defines.svh @@
// Assertion macros for the masked byte pattern search core.
// Used by the top level; depends on nothing else.
`ifndef MASKED_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MBPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbps assertion failed");

// Antecedent implies consequent in the next cycle.
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbps assertion failed");

`endif

@@ hw/rtl/mbps_pkg.sv @@
// Shared constants, register indexes and types of the masked byte pattern search core.
// Used by the other files but the defines header and mbps_item_if; depends on nothing.
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES = 32;
  localparam int OFFSET_BITS       = 32;
  localparam int LEN_BITS          = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_BITS          = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int PATTERN_WORDS     = 4;
  localparam int WORD_BITS         = 64;
  localparam int WILDCARD_BITS     = 32;
  localparam int PLEN_BITS         = 6;
  localparam int ADDR_BITS         = 64;
  localparam int CFG_INDEX_BITS    = 3;

  localparam logic [OFFSET_BITS-1:0] COUNT_LIMIT = '1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_ZERO  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_ONE   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_TWO   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_THREE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WILDCARD_BITS      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_ADDRESS       = 3'd6;

  typedef struct packed {
    logic [MAX_PATTERN_BYTES-1:0][7:0] aligned_pattern;
    logic [MAX_PATTERN_BYTES-1:0]      care;
    logic [LEN_BITS-1:0]               length;
    logic [ADDR_BITS-1:0]              base_address;
  } scan_cfg_t;

  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [ADDR_BITS-1:0] address;
  } scan_res_t;

endpackage

@@ hw/rtl/mbps_item_if.sv @@
// Input channel of the masked byte pattern search core: one image byte per transfer.
// Depends on nothing.
interface mbps_item_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic end_of_image;

  modport source (output valid, output data_byte, output end_of_image, input ready);
  modport sink (input valid, input data_byte, input end_of_image, output ready);
endinterface

@@ hw/rtl/mbps_result_if.sv @@
// Result channel of the masked byte pattern search core.
// Depends on mbps_pkg.
interface mbps_result_if
  import mbps_pkg::*;
;
  logic valid;
  logic ready;
  logic match_found;
  logic [ADDR_BITS-1:0] match_address;

  modport source (output valid, output match_found, output match_address, input ready);
  modport sink (input valid, input match_found, input match_address, output ready);
endinterface

@@ hw/rtl/mbps_cfg_if.sv @@
// Configuration write channel of the masked byte pattern search core.
// Depends on mbps_pkg.
interface mbps_cfg_if
  import mbps_pkg::*;
;
  logic valid;
  logic ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [WORD_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/masked_byte_pattern_search_core.sv @@
// Masked byte pattern search core: top level with input and result registers.
// Input bytes are registered; any result a byte yields goes to the result register.
// Throughput: one byte per cycle unless the result stalls, set by the masked compare.
// Reset (synchronous, active high) clears the window, counter, found flag and pipeline,
// and returns the configuration registers to their reset values.
module masked_byte_pattern_search_core
  import mbps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  mbps_cfg_if.sink     cfg,
  mbps_item_if.sink    scan_item,
  mbps_result_if.source scan_result
);

`include "masked_byte_pattern_search_core_defines.svh"

  scan_cfg_t scan_cfg;
  scan_res_t eng_result;
  logic scan_found;

  logic in_valid;
  logic [7:0] in_byte;
  logic in_last;
  logic fire;

  logic out_valid;
  logic out_found;
  logic [ADDR_BITS-1:0] out_address;

  mbps_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .scan_cfg (scan_cfg)
  );

  mbps_scan_engine u_scan_engine (
    .clk          (clk),
    .rst          (rst),
    .step         (fire),
    .data_byte    (in_byte),
    .end_of_image (in_last),
    .scan_cfg     (scan_cfg),
    .result       (eng_result),
    .found        (scan_found)
  );

  assign fire = in_valid && (!out_valid || scan_result.ready);
  assign scan_item.ready = !rst && (!in_valid || fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (scan_item.valid && scan_item.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_item.valid && scan_item.ready) begin
      in_byte <= scan_item.data_byte;
      in_last <= scan_item.end_of_image;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && eng_result.valid) begin
      out_valid <= 1'b1;
    end else if (scan_result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && eng_result.valid) begin
      out_found   <= eng_result.found;
      out_address <= eng_result.address;
    end
  end

  assign scan_result.valid         = out_valid;
  assign scan_result.match_found   = out_found;
  assign scan_result.match_address = out_address;

  `MBPS_ASSERT_NOW(a_not_found_zero_address, clk, rst, out_valid && !out_found, out_address == '0)
  `MBPS_ASSERT_NEXT(a_clear_after_last, clk, rst, fire && in_last, !scan_found)
  `MBPS_ASSERT_NOW(a_found_reported, clk, rst, $rose(scan_found), out_valid && out_found)

endmodule

@@ hw/rtl/mbps_cfg_regs.sv @@
// Configuration registers and the pattern aligned to the sliding window.
// Depends on mbps_pkg and mbps_cfg_if.
module mbps_cfg_regs
  import mbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mbps_cfg_if.sink   cfg,
  output scan_cfg_t  scan_cfg
);

  logic [PATTERN_WORDS-1:0][WORD_BITS-1:0] pattern_words;
  logic [WILDCARD_BITS-1:0] wildcard_bits;
  logic [PLEN_BITS-1:0] pattern_length;
  logic [ADDR_BITS-1:0] base_address;

  logic [PATTERN_WORDS*WORD_BITS-1:0] pattern_flat;
  logic [MAX_PATTERN_BYTES-1:0][7:0] pattern_bytes;
  logic [LEN_BITS-1:0] eff_len;
  scan_cfg_t scan_cfg_next;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_words  <= '0;
      wildcard_bits  <= '0;
      pattern_length <= PLEN_BITS'(1);
      base_address   <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_PATTERN_WORD_ZERO:  pattern_words[0] <= cfg.data;
        REG_PATTERN_WORD_ONE:   pattern_words[1] <= cfg.data;
        REG_PATTERN_WORD_TWO:   pattern_words[2] <= cfg.data;
        REG_PATTERN_WORD_THREE: pattern_words[3] <= cfg.data;
        REG_WILDCARD_BITS:      wildcard_bits <= cfg.data[WILDCARD_BITS-1:0];
        REG_PATTERN_LENGTH:     pattern_length <= cfg.data[PLEN_BITS-1:0];
        REG_BASE_ADDRESS:       base_address <= cfg.data;
        default: ;
      endcase
    end
  end

  assign pattern_flat  = pattern_words;
  assign pattern_bytes = pattern_flat[MAX_PATTERN_BYTES*8-1:0];

  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (32'(pattern_length) > MAX_PATTERN_BYTES) begin
      eff_len = LEN_BITS'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = LEN_BITS'(pattern_length);
    end
  end

  // Window tap a holds the byte that pattern byte (length - 1 - a) must match.
  always_comb begin
    logic [LEN_BITS-1:0] j;
    logic in_use;
    scan_cfg_next.length       = eff_len;
    scan_cfg_next.base_address = base_address;
    for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
      in_use = LEN_BITS'(a) < eff_len;
      j = eff_len - LEN_BITS'(a + 1);
      scan_cfg_next.aligned_pattern[a] = in_use ? pattern_bytes[j[IDX_BITS-1:0]] : 8'h00;
      scan_cfg_next.care[a] = in_use && !wildcard_bits[j[IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cfg <= '{aligned_pattern: '0,
                    care:            MAX_PATTERN_BYTES'(1),
                    length:          LEN_BITS'(1),
                    base_address:    '0};
    end else begin
      scan_cfg <= scan_cfg_next;
    end
  end

endmodule

@@ hw/rtl/mbps_scan_engine.sv @@
// Sliding byte window, byte counter and found flag, with the masked window compare.
// Depends on mbps_pkg.
module mbps_scan_engine
  import mbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       end_of_image,
  input  scan_cfg_t  scan_cfg,
  output scan_res_t  result,
  output logic       found
);

  logic [MAX_PATTERN_BYTES-1:0][7:0] window;
  logic [MAX_PATTERN_BYTES-1:0][7:0] window_next;
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] count_next;
  logic [OFFSET_BITS-1:0] offset;
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic active;
  logic hit;

  assign active = !found && (bytes_seen != COUNT_LIMIT);
  assign count_next = bytes_seen + OFFSET_BITS'(1);

  always_comb begin
    window_next[0] = data_byte;
    for (int a = 1; a < MAX_PATTERN_BYTES; a++) begin
      window_next[a] = window[a-1];
    end
    for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
      byte_ok[a] = !scan_cfg.care[a] || (window_next[a] == scan_cfg.aligned_pattern[a]);
    end
  end

  assign hit = active && (count_next >= OFFSET_BITS'(scan_cfg.length)) && (&byte_ok);
  assign offset = count_next - OFFSET_BITS'(scan_cfg.length);

  always_comb begin
    result.valid   = step && (hit || (end_of_image && !found));
    result.found   = hit;
    result.address = hit ? scan_cfg.base_address + ADDR_BITS'(offset) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      bytes_seen <= '0;
      found      <= 1'b0;
    end else if (step) begin
      if (end_of_image) begin
        window     <= '0;
        bytes_seen <= '0;
        found      <= 1'b0;
      end else if (active) begin
        window     <= window_next;
        bytes_seen <= count_next;
        found      <= hit;
      end
    end
  end

endmodule
